>>> rtl/gpce_pkg.sv
// Shared types, constants and the nibble code table of the guide pulse command encoder.
package gpce_pkg;

   // Request kinds carried in the cmd field.
   localparam logic CMD_TICK  = 1'b0;
   localparam logic CMD_GUIDE = 1'b1;

   // Guide directions; the codes above DIR_NONE mean nothing and are ignored.
   typedef enum logic [2:0] {
      DIR_NORTH = 3'd0,
      DIR_SOUTH = 3'd1,
      DIR_EAST  = 3'd2,
      DIR_WEST  = 3'd3,
      DIR_NONE  = 3'd4
   } dir_type;

   // Command word bits, active low.
   localparam logic [15:0] BTN_NORTH = 16'h0001;
   localparam logic [15:0] BTN_SOUTH = 16'h0002;
   localparam logic [15:0] BTN_WEST  = 16'h0004;
   localparam logic [15:0] BTN_EAST  = 16'h0008;
   localparam logic [15:0] BTN_SPEED = 16'h0010;
   localparam logic [15:0] WORD_IDLE = 16'hFFFF;

   localparam int unsigned TICKS_W   = 10;
   localparam logic [TICKS_W-1:0] TICKS_MAX = 10'd1023;

   // Hamming(8,4) code of one nibble.
   function automatic logic [7:0] nibble_code(input logic [3:0] nib);
      logic [7:0] code;
      case (nib)
         4'h0: code = 8'h00;
         4'h1: code = 8'hE1;
         4'h2: code = 8'hD2;
         4'h3: code = 8'h33;
         4'h4: code = 8'hB4;
         4'h5: code = 8'h55;
         4'h6: code = 8'h66;
         4'h7: code = 8'h87;
         4'h8: code = 8'h78;
         4'h9: code = 8'h99;
         4'hA: code = 8'hAA;
         4'hB: code = 8'h4B;
         4'hC: code = 8'hCC;
         4'hD: code = 8'h2D;
         4'hE: code = 8'h1E;
         default: code = 8'hFF;
      endcase
      return code;
   endfunction

endpackage

>>> rtl/guide_pulse_command_encoder.sv
// Guide pulse command encoder: button word, per-axis tick counters and coded frame output.
// A tick beat passes the input register and then the frame register before its first
// coded byte is offered; a guide beat gives no result. Guide beats are taken one per
// cycle while no tick beat waits in the input register. A tick beat waits there until
// the frame register is empty or the last of the four bytes of the previous frame leaves;
// the bytes leave one per cycle through the frame register unless the receiver stalls.
// Reset (synchronous): the word returns to all buttons released, both counters to zero,
// and the input and frame registers are emptied.
module guide_pulse_command_encoder
   import gpce_pkg::*;
#(
   parameter int unsigned TICK_MS = 100
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_cmd,
   input  logic [2:0]          req_direction,
   input  logic [15:0]         req_duration_ms,
   input  logic                req_fast,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [7:0]          rsp_line_byte,
   output logic                rsp_last,
   output logic [TICKS_W-1:0]  rsp_busy_ticks
);

   // The pulse length in ticks is (d + TICK_MS/2) / TICK_MS. The division is done
   // as a multiplication by a rounded-up reciprocal; with a 17-bit dividend and a
   // divisor below 1024, a 27-bit scale makes the truncated product exact.
   localparam int unsigned HALF        = TICK_MS / 2;
   localparam int unsigned DIVIDEND_W  = 17;
   localparam int unsigned RECIP_SHIFT = 27;
   localparam int unsigned RECIP_W     = 28;
   localparam int unsigned PROD_W      = DIVIDEND_W + RECIP_W;
   localparam int unsigned QUOT_W      = PROD_W - RECIP_SHIFT;
   localparam logic [RECIP_W-1:0] RECIP =
      RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(TICK_MS) - 64'd1) / 64'(TICK_MS));

   // Input register: one accepted beat waits here until it can be worked on.
   logic                in_valid_ff, in_valid_in;
   logic                in_cmd_ff;
   logic [2:0]          in_dir_ff;
   logic [15:0]         in_dur_ff;
   logic                in_fast_ff;

   // Block state.
   logic [15:0]         word_ff, word_in;
   logic [TICKS_W-1:0]  ax_ew_ff, ax_ew_in;   // east/west axis
   logic [TICKS_W-1:0]  ax_ns_ff, ax_ns_in;   // north/south axis

   // Frame register: four coded bytes, shifted out low byte first.
   logic [2:0]          frame_cnt_ff, frame_cnt_in;
   logic [31:0]         frame_ff, frame_in;
   logic [TICKS_W-1:0]  busy_ff, busy_in;

   logic                req_take;
   logic                rsp_take;
   logic                frame_free;
   logic                proc;
   logic                proc_tick;
   logic                proc_guide;

   logic [DIVIDEND_W-1:0] dividend;
   logic [PROD_W-1:0]     product;
   logic [QUOT_W-1:0]     quotient;
   logic [TICKS_W-1:0]    pulse_ticks;

   logic [15:0]         change;
   logic [15:0]         value;
   logic                guide_ok;
   logic                load_ew;
   logic                load_ns;
   logic                clear_axes;
   logic [TICKS_W-1:0]  ew_dec;
   logic [TICKS_W-1:0]  ns_dec;
   logic [15:0]         word_tick;

   assign rsp_take = rsp_valid & ~rsp_stall;

   // The frame register can take a new frame when it is empty or its final
   // byte leaves in this cycle. Guide beats never need it.
   assign frame_free = (frame_cnt_ff == 3'd0) || ((frame_cnt_ff == 3'd1) && rsp_take);
   assign proc       = in_valid_ff & ((in_cmd_ff == CMD_GUIDE) | frame_free);
   assign proc_tick  = proc & (in_cmd_ff == CMD_TICK);
   assign proc_guide = proc & (in_cmd_ff == CMD_GUIDE);

   // The input register is free when empty or when its beat is worked on now.
   assign req_stall = in_valid_ff & ~proc;
   assign req_take  = req_valid & ~req_stall;
   assign in_valid_in = req_take | (in_valid_ff & ~proc);

   // Pulse length in ticks, with the short-pulse floor and saturation.
   assign dividend = DIVIDEND_W'(in_dur_ff) + DIVIDEND_W'(HALF);
   assign product  = PROD_W'(dividend) * PROD_W'(RECIP);
   assign quotient = product[PROD_W-1:RECIP_SHIFT];

   always_comb begin
      if (32'(in_dur_ff) < 32'(HALF)) begin
         pulse_ticks = TICKS_W'(1);
      end else if (quotient > QUOT_W'(TICKS_MAX)) begin
         pulse_ticks = TICKS_MAX;
      end else begin
         pulse_ticks = quotient[TICKS_W-1:0];
      end
   end

   // Guide request decode: which buttons change, to what, and which counter loads.
   always_comb begin
      change     = BTN_NORTH | BTN_SOUTH;
      value      = WORD_IDLE;
      guide_ok   = 1'b1;
      load_ew    = 1'b0;
      load_ns    = 1'b0;
      clear_axes = 1'b0;
      case (in_dir_ff)
         DIR_NORTH: begin
            change  = BTN_NORTH | BTN_SOUTH;
            value   = ~BTN_NORTH;
            load_ns = 1'b1;
         end
         DIR_SOUTH: begin
            change  = BTN_NORTH | BTN_SOUTH;
            value   = ~BTN_SOUTH;
            load_ns = 1'b1;
         end
         DIR_EAST: begin
            change  = BTN_WEST | BTN_EAST;
            value   = ~BTN_EAST;
            load_ew = 1'b1;
         end
         DIR_WEST: begin
            change  = BTN_WEST | BTN_EAST;
            value   = ~BTN_WEST;
            load_ew = 1'b1;
         end
         DIR_NONE: begin
            change     = BTN_NORTH | BTN_SOUTH | BTN_WEST | BTN_EAST;
            value      = WORD_IDLE;
            clear_axes = 1'b1;
         end
         default: begin
            guide_ok = 1'b0;
         end
      endcase
      // A zero duration leaves everything alone, the speed bit included.
      if (in_dur_ff == 16'd0) begin
         guide_ok = 1'b0;
      end
      change = change | BTN_SPEED;
      if (in_fast_ff) begin
         value = value & ~BTN_SPEED;
      end else begin
         value = value | BTN_SPEED;
      end
   end

   // Tick countdown; an axis whose counter reaches zero has its buttons released.
   always_comb begin
      ew_dec    = ax_ew_ff;
      ns_dec    = ax_ns_ff;
      word_tick = word_ff;
      if (ax_ew_ff != '0) begin
         ew_dec = ax_ew_ff - TICKS_W'(1);
         if (ew_dec == '0) begin
            word_tick = word_tick | BTN_WEST | BTN_EAST;
         end
      end
      if (ax_ns_ff != '0) begin
         ns_dec = ax_ns_ff - TICKS_W'(1);
         if (ns_dec == '0) begin
            word_tick = word_tick | BTN_NORTH | BTN_SOUTH;
         end
      end
   end

   // Next state of the word, the counters and the frame register.
   always_comb begin
      word_in      = word_ff;
      ax_ew_in     = ax_ew_ff;
      ax_ns_in     = ax_ns_ff;
      frame_cnt_in = frame_cnt_ff;
      frame_in     = frame_ff;
      busy_in      = busy_ff;

      if (rsp_take) begin
         frame_cnt_in = frame_cnt_ff - 3'd1;
         frame_in     = {8'h00, frame_ff[31:8]};
      end

      if (proc_guide && guide_ok) begin
         word_in = (word_ff & ~change) | (value & change);
         if (clear_axes) begin
            ax_ew_in = '0;
            ax_ns_in = '0;
         end
         if (load_ew) begin
            ax_ew_in = pulse_ticks;
         end
         if (load_ns) begin
            ax_ns_in = pulse_ticks;
         end
      end

      // The frame carries the word as it stood before this tick's countdown.
      if (proc_tick) begin
         frame_cnt_in = 3'd4;
         frame_in     = {nibble_code(word_ff[15:12]), nibble_code(word_ff[11:8]),
                         nibble_code(word_ff[7:4]),   nibble_code(word_ff[3:0])};
         busy_in      = (ew_dec > ns_dec) ? ew_dec : ns_dec;
         word_in      = word_tick;
         ax_ew_in     = ew_dec;
         ax_ns_in     = ns_dec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         word_ff      <= WORD_IDLE;
         ax_ew_ff     <= '0;
         ax_ns_ff     <= '0;
         frame_cnt_ff <= 3'd0;
      end else begin
         in_valid_ff  <= in_valid_in;
         word_ff      <= word_in;
         ax_ew_ff     <= ax_ew_in;
         ax_ns_ff     <= ax_ns_in;
         frame_cnt_ff <= frame_cnt_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_cmd_ff  <= req_cmd;
         in_dir_ff  <= req_direction;
         in_dur_ff  <= req_duration_ms;
         in_fast_ff <= req_fast;
      end
      frame_ff <= frame_in;
      busy_ff  <= busy_in;
   end

   assign rsp_valid      = (frame_cnt_ff != 3'd0);
   assign rsp_line_byte  = frame_ff[7:0];
   assign rsp_last       = (frame_cnt_ff == 3'd1);
   assign rsp_busy_ticks = busy_ff;

endmodule

>>> sim/tb.sv
// Self-checking testbench for the guide pulse command encoder.
`timescale 1ns / 100ps

module tb;
   import gpce_pkg::*;

   localparam int unsigned TICK_MS       = 100;
   localparam int unsigned HALF_TICK_MS  = TICK_MS / 2;
   localparam int          CYCLE_LIMIT   = 100000;
   localparam int          LONG_HOLD     = 300;
   localparam int          SETTLE_CYCLES = 8;
   localparam int          RANDOM_BEATS  = 164;
   localparam int          AXIS_EW       = 0;
   localparam int          AXIS_NS       = 1;

   // Direction codes beyond DIR_NONE carry no meaning and must be ignored.
   localparam logic [2:0] DIR_SPARE_5 = 3'd5;
   localparam logic [2:0] DIR_SPARE_6 = 3'd6;
   localparam logic [2:0] DIR_SPARE_7 = 3'd7;

   // Hamming(8,4) code of each nibble, entry n held at bits [8n+7:8n].
   localparam logic [127:0] HAMMING_TABLE = {
      8'hFF, 8'h1E, 8'h2D, 8'hCC, 8'h4B, 8'hAA, 8'h99, 8'h78,
      8'h87, 8'h66, 8'h55, 8'hB4, 8'h33, 8'hD2, 8'hE1, 8'h00
   };

   typedef struct packed {
      logic [7:0]         line_byte;
      logic               last;
      logic [TICKS_W-1:0] busy_ticks;
   } coded_byte_type;

   logic               clock           = 1'b0;
   logic               reset           = 1'b1;
   logic               req_valid       = 1'b0;
   logic               req_cmd         = CMD_TICK;
   logic [2:0]         req_direction   = DIR_NORTH;
   logic [15:0]        req_duration_ms = 16'd0;
   logic               req_fast        = 1'b0;
   logic               rsp_stall       = 1'b0;
   logic               req_stall;
   logic               rsp_valid;
   logic [7:0]         rsp_line_byte;
   logic               rsp_last;
   logic [TICKS_W-1:0] rsp_busy_ticks;

   // Our own copy of the button word and the two axis countdowns.
   logic [15:0]        word_model;
   logic [TICKS_W-1:0] axis_model [2];

   // Coded bytes still owed by the block, oldest first.
   coded_byte_type frame_bytes_due[$];

   int fail_count  = 0;
   int cycle_count = 0;

   // Long receiver hold-off, requested by the stimulus and timed by the receiver.
   int hold_asked = 0;
   int hold_done  = 0;
   int hold_left  = 0;
   logic [15:0] stall_pattern = 16'h0000;
   logic [3:0]  pattern_pos   = 4'd0;

   guide_pulse_command_encoder #(
      .TICK_MS(TICK_MS)
   ) u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_cmd         (req_cmd),
      .req_direction   (req_direction),
      .req_duration_ms (req_duration_ms),
      .req_fast        (req_fast),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_line_byte   (rsp_line_byte),
      .rsp_last        (rsp_last),
      .rsp_busy_ticks  (rsp_busy_ticks)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // A hard ceiling on the run so that a hung block cannot stall the simulation.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("** guide_pulse_command_encoder: FAILED **");
         $finish;
      end
   end

   // Pulse length in ticks: short pulses still get one tick, longer ones are rounded
   // to the nearest tick and held at or below the counter's ceiling.
   function automatic logic [TICKS_W-1:0] ticks_for_pulse(input logic [15:0] dur_ms);
      int unsigned t;
      if (dur_ms < HALF_TICK_MS) begin
         t = 1;
      end else begin
         t = (dur_ms + HALF_TICK_MS) / TICK_MS;
         if (t > TICKS_MAX) t = TICKS_MAX;
      end
      return t[TICKS_W-1:0];
   endfunction

   // A guide beat presses one button of an axis and releases its partner, or
   // releases everything for a stop; zero length and spare codes leave all alone.
   task automatic apply_guide(input logic [2:0] dir, input logic [15:0] dur_ms,
                              input logic fast);
      logic [15:0] change;
      logic [15:0] value;
      int          axis;
      logic        known;
      known = 1'b1;
      axis  = -1;
      change = '0;
      value  = WORD_IDLE;
      case (dir)
         DIR_NORTH: begin
            change = BTN_NORTH | BTN_SOUTH; value = ~BTN_NORTH; axis = AXIS_NS;
         end
         DIR_SOUTH: begin
            change = BTN_NORTH | BTN_SOUTH; value = ~BTN_SOUTH; axis = AXIS_NS;
         end
         DIR_EAST: begin
            change = BTN_WEST | BTN_EAST; value = ~BTN_EAST; axis = AXIS_EW;
         end
         DIR_WEST: begin
            change = BTN_WEST | BTN_EAST; value = ~BTN_WEST; axis = AXIS_EW;
         end
         DIR_NONE: begin
            change = BTN_NORTH | BTN_SOUTH | BTN_WEST | BTN_EAST;
         end
         default: known = 1'b0;
      endcase
      if (known && dur_ms != 16'd0) begin
         change = change | BTN_SPEED;
         value  = fast ? (value & ~BTN_SPEED) : (value | BTN_SPEED);
         word_model = (word_model & ~change) | (value & change);
         if (axis < 0) begin
            axis_model[AXIS_EW] = '0;
            axis_model[AXIS_NS] = '0;
         end else begin
            axis_model[axis] = ticks_for_pulse(dur_ms);
         end
      end
   endtask

   // A tick sends the word as it stands, then counts both axes down; an axis that
   // reaches zero has its buttons released.
   task automatic emit_frame();
      logic [15:0]        sent;
      logic [TICKS_W-1:0] busy;
      coded_byte_type     entry;
      int                 nib;
      sent = word_model;
      if (axis_model[AXIS_EW] != 0) begin
         axis_model[AXIS_EW] = axis_model[AXIS_EW] - 1'b1;
         if (axis_model[AXIS_EW] == 0) word_model = word_model | BTN_WEST | BTN_EAST;
      end
      if (axis_model[AXIS_NS] != 0) begin
         axis_model[AXIS_NS] = axis_model[AXIS_NS] - 1'b1;
         if (axis_model[AXIS_NS] == 0) word_model = word_model | BTN_NORTH | BTN_SOUTH;
      end
      busy = (axis_model[AXIS_EW] > axis_model[AXIS_NS]) ? axis_model[AXIS_EW]
                                                         : axis_model[AXIS_NS];
      for (int i = 0; i < 4; i++) begin
         nib = sent[i*4 +: 4];
         entry.line_byte  = HAMMING_TABLE[nib*8 +: 8];
         entry.last       = (i == 3);
         entry.busy_ticks = busy;
         frame_bytes_due.push_back(entry);
      end
   endtask

   // Offers one beat and holds it until the block takes it. Valid is left high so
   // that a following beat can go straight out on the next edge.
   task automatic send_beat(input logic cmd, input logic [2:0] dir,
                            input logic [15:0] dur_ms, input logic fast);
      req_valid       <= 1'b1;
      req_cmd         <= cmd;
      req_direction   <= dir;
      req_duration_ms <= dur_ms;
      req_fast        <= fast;
      do @(posedge clock); while (req_stall);
      if (cmd == CMD_TICK) emit_frame();
      else apply_guide(dir, dur_ms, fast);
   endtask

   task automatic send_tick();
      logic [31:0] junk;
      junk = $urandom;
      send_beat(CMD_TICK, junk[2:0], junk[18:3], junk[19]);
   endtask

   task automatic pause_sender(input int cycles);
      if (cycles > 0) begin
         req_valid <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   // The sender stops until every owed byte has come back, then lets the block settle.
   task automatic wait_until_drained();
      req_valid <= 1'b0;
      while (frame_bytes_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic flag_mismatch(input string field, input int unsigned want,
                                input int unsigned got);
      fail_count++;
      $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h", $time, field, want, got);
   endtask

   // Receiver: stalls on a pattern that is redrawn whenever its bit position wraps, sometimes
   // not at all and sometimes heavily, unless a long hold-off has been requested.
   always @(posedge clock) begin
      if (hold_done != hold_asked) begin
         hold_done <= hold_asked;
         hold_left <= LONG_HOLD;
         rsp_stall <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         if (pattern_pos == 4'd0) begin
            case ($urandom_range(0, 3))
               0:       stall_pattern <= 16'h0000;
               1:       stall_pattern <= 16'($urandom & $urandom);
               2:       stall_pattern <= 16'($urandom);
               default: stall_pattern <= 16'($urandom | $urandom);
            endcase
         end
         rsp_stall   <= stall_pattern[pattern_pos];
         pattern_pos <= pattern_pos + 4'd1;
      end
   end

   // Every byte the block hands over is matched against the oldest owed byte.
   always @(posedge clock) begin : check_results
      coded_byte_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (frame_bytes_due.size() == 0) begin
            fail_count++;
            $display("%0t ns: unexpected beat, expected none, got line_byte 0x%0h",
                     $time, rsp_line_byte);
         end else begin
            want = frame_bytes_due.pop_front();
            if (rsp_line_byte !== want.line_byte)
               flag_mismatch("line_byte", want.line_byte, rsp_line_byte);
            if (rsp_last !== want.last)
               flag_mismatch("last", want.last, rsp_last);
            if (rsp_busy_ticks !== want.busy_ticks)
               flag_mismatch("busy_ticks", want.busy_ticks, rsp_busy_ticks);
         end
      end
   end

   // The word straight after reset: every button released, slow speed.
   task automatic test_reset_frame();
      send_tick();
      wait_until_drained();
   endtask

   // Pulse rounding around half a tick, the overwrite of one axis by its partner,
   // and release of each axis as its count runs out.
   task automatic test_pulse_lengths();
      send_beat(CMD_GUIDE, DIR_NORTH, 16'd1, 1'b1);
      send_tick();
      send_tick();
      send_beat(CMD_GUIDE, DIR_SOUTH, 16'd49, 1'b0);
      send_beat(CMD_GUIDE, DIR_EAST, 16'd50, 1'b1);
      send_beat(CMD_GUIDE, DIR_WEST, 16'd150, 1'b0);
      send_tick();
      send_tick();
      send_tick();
      wait_until_drained();
   endtask

   // Spare direction codes and zero-length pulses must leave the word untouched,
   // the speed bit included.
   task automatic test_ignored_requests();
      send_beat(CMD_GUIDE, DIR_SPARE_5, 16'd100, 1'b1);
      send_beat(CMD_GUIDE, DIR_SPARE_6, 16'hFFFF, 1'b1);
      send_beat(CMD_GUIDE, DIR_SPARE_7, 16'd300, 1'b0);
      send_beat(CMD_GUIDE, DIR_NORTH, 16'd0, 1'b1);
      send_tick();
      wait_until_drained();
   endtask

   // The longest pulse, then a stop that clears both axes; idle counters stay at zero.
   task automatic test_stop_all();
      send_beat(CMD_GUIDE, DIR_NORTH, 16'hFFFF, 1'b1);
      send_beat(CMD_GUIDE, DIR_EAST, 16'd149, 1'b1);
      send_tick();
      send_beat(CMD_GUIDE, DIR_NONE, 16'd1, 1'b0);
      send_tick();
      send_tick();
      wait_until_drained();
   endtask

   // The receiver holds off for a long stretch while ticks keep coming, so the
   // block has to fill up and push back on its input.
   task automatic test_back_pressure();
      hold_asked <= hold_asked + 1;
      send_beat(CMD_GUIDE, DIR_SOUTH, 16'd250, 1'b1);
      for (int i = 0; i < 24; i++) send_tick();
      wait_until_drained();
   endtask

   // Mostly well-formed guide and tick traffic in bursts, with some noise mixed in.
   task automatic test_random_traffic();
      int          counted;
      int          burst_left;
      int          pick;
      logic [31:0] rnd;
      logic [2:0]  dir;
      logic [15:0] dur_ms;
      counted    = 0;
      burst_left = 0;
      while (counted < RANDOM_BEATS) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 8));
         end
         burst_left--;
         pick = $urandom_range(0, 19);
         rnd  = $urandom;
         if (pick < 9) begin
            send_tick();
         end else if (pick < 18) begin
            dir    = ($urandom_range(0, 9) == 0) ? DIR_NONE : 3'($urandom_range(0, 3));
            dur_ms = ($urandom_range(0, 7) == 0) ? rnd[15:0] : 16'($urandom_range(1, 700));
            send_beat(CMD_GUIDE, dir, dur_ms, rnd[16]);
         end else if (pick == 18) begin
            send_beat(CMD_GUIDE, 3'($urandom_range(5, 7)), rnd[15:0], rnd[16]);
         end else begin
            send_beat(CMD_GUIDE, 3'($urandom_range(0, 4)), 16'd0, rnd[16]);
         end
         counted++;
      end
      wait_until_drained();
   endtask

   initial begin
      word_model          = WORD_IDLE;
      axis_model[AXIS_EW] = '0;
      axis_model[AXIS_NS] = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_frame();
      test_pulse_lengths();
      test_ignored_requests();
      test_stop_all();
      test_back_pressure();
      test_random_traffic();

      if (fail_count == 0 && frame_bytes_due.size() == 0) begin
         $display("** guide_pulse_command_encoder: PASSED **");
      end else begin
         $display("** guide_pulse_command_encoder: FAILED **");
      end
      $finish;
   end

endmodule

>>> sim.f
rtl/gpce_pkg.sv
rtl/guide_pulse_command_encoder.sv
sim/tb.sv
